>>> hdl/kpp_pkg.sv
// Shared constants, types and helpers of the k-mer presence profiler.
package kpp_pkg;

  localparam int KPP_MAX_K  = 8;
  localparam int KPP_CODE_W = 2 * KPP_MAX_K;
  localparam int KPP_IDX_W  = 2 * KPP_MAX_K + 1;
  localparam int KPP_CNT_W  = 4;
  localparam int KPP_CFG_W  = 4;
  localparam logic [KPP_CFG_W-1:0] KPP_KMER_LEN_RST = KPP_CFG_W'(8);

  // Bitmap storage: rows of 32 presence bits plus an epoch tag
  localparam int KPP_ROW_SHIFT = 5;
  localparam int KPP_ROW_BITS  = 1 << KPP_ROW_SHIFT;
  localparam longint KPP_MAP_BITS = (longint'(1) << KPP_CODE_W) + longint'(1);
  localparam int KPP_RAM_DEPTH =
    int'((KPP_MAP_BITS + longint'(KPP_ROW_BITS) - longint'(1)) / longint'(KPP_ROW_BITS));
  localparam int KPP_ADDR_W  = (KPP_RAM_DEPTH > 1) ? $clog2(KPP_RAM_DEPTH) : 1;
  localparam int KPP_EPOCH_W = 8;

  // Result queue
  localparam int KPP_FIFO_DEPTH = 3;
  localparam int KPP_FIFO_PTR_W = $clog2(KPP_FIFO_DEPTH);
  localparam int KPP_FIFO_CNT_W = $clog2(KPP_FIFO_DEPTH + 1);

  // APB register file
  localparam int KPP_APB_ADDR_W = 3;
  localparam int KPP_APB_DATA_W = 32;
  localparam logic [KPP_APB_ADDR_W-3:0] KPP_REG_KMER_LEN = '0;

  // Character codes
  localparam logic [7:0] KPP_CH_A       = 8'h41;
  localparam logic [7:0] KPP_CH_C       = 8'h43;
  localparam logic [7:0] KPP_CH_G       = 8'h47;
  localparam logic [7:0] KPP_CH_T       = 8'h54;
  localparam logic [7:0] KPP_CH_U       = 8'h55;
  localparam logic [7:0] KPP_CH_LOW_A   = 8'h61;
  localparam logic [7:0] KPP_CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] KPP_CASE_OFS   = 8'd32;

  localparam logic [1:0] KPP_SYM_A = 2'd0;
  localparam logic [1:0] KPP_SYM_C = 2'd1;
  localparam logic [1:0] KPP_SYM_G = 2'd2;
  localparam logic [1:0] KPP_SYM_T = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } kpp_sym_t;

  typedef struct packed {
    logic                 valid;
    logic                 full;
    logic [KPP_IDX_W-1:0] idx;
    logic                 eos;
  } kpp_req_t;

  typedef struct packed {
    logic                 window_full;
    logic [KPP_IDX_W-1:0] kmer_index;
    logic                 first_seen;
    logic [KPP_IDX_W-1:0] distinct_count;
    logic                 sequence_done;
  } kpp_res_t;

  typedef struct packed {
    logic busy;
    logic s1_valid;
  } kpp_stat_t;

  function automatic kpp_sym_t kpp_base_sym(input logic [7:0] ch);
    logic [7:0] up;
    kpp_sym_t   s;
    up = (ch >= KPP_CH_LOW_A && ch <= KPP_CH_LOW_Z) ? ch - KPP_CASE_OFS : ch;
    s.valid = 1'b1;
    case (up)
      KPP_CH_A: s.code = KPP_SYM_A;
      KPP_CH_C: s.code = KPP_SYM_C;
      KPP_CH_G: s.code = KPP_SYM_G;
      KPP_CH_T, KPP_CH_U: s.code = KPP_SYM_T;
      default: begin
        s.valid = 1'b0;
        s.code  = KPP_SYM_A;
      end
    endcase
    return s;
  endfunction

endpackage

>>> hdl/kpp_in_if.sv
// Input request channel: one sequence character per request.
interface kpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       end_of_sequence;

  modport source (output valid, base_char, end_of_sequence, input ready);
  modport sink   (input valid, base_char, end_of_sequence, output ready);
endinterface

>>> hdl/kpp_out_if.sv
// Result channel: one profile result per request.
interface kpp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         window_full;
  logic [kpp_pkg::KPP_IDX_W-1:0] kmer_index;
  logic                         first_seen;
  logic [kpp_pkg::KPP_IDX_W-1:0] distinct_count;
  logic                         sequence_done;

  modport source (output valid, window_full, kmer_index, first_seen, distinct_count,
                  sequence_done, input ready);
  modport sink   (input valid, window_full, kmer_index, first_seen, distinct_count,
                  sequence_done, output ready);
endinterface

>>> hdl/kpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/kpp_window.sv
// Rolling k-mer window: base decode, code history and index formation.
module kpp_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [7:0]                    base_char,
  input  logic                          eos,
  input  logic [kpp_pkg::KPP_CFG_W-1:0] kmer_len,
  output kpp_pkg::kpp_req_t             req
);

  localparam int CODE_W = kpp_pkg::KPP_CODE_W;
  localparam int IDX_W  = kpp_pkg::KPP_IDX_W;
  localparam int CNT_W  = kpp_pkg::KPP_CNT_W;
  localparam logic [CNT_W-1:0] MAX_K = CNT_W'(kpp_pkg::KPP_MAX_K);

  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CNT_W-1:0]  vrun_r, vrun_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  k_eff;
  logic [IDX_W-1:0]  span;
  logic [IDX_W-1:0]  idx;
  logic              full;
  kpp_pkg::kpp_sym_t sym;

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = CNT_W'(1);
    end else if (CNT_W'(kmer_len) > MAX_K) begin
      k_eff = MAX_K;
    end else begin
      k_eff = CNT_W'(kmer_len);
    end
  end

  always_comb begin
    sym = kpp_pkg::kpp_base_sym(base_char);
    // invalid characters shift in a zero digit
    code_nxt = CODE_W'({code_r, (sym.valid ? sym.code : 2'b00)});
    if (!sym.valid) begin
      vrun_nxt = '0;
    end else if (vrun_r < MAX_K) begin
      vrun_nxt = vrun_r + CNT_W'(1);
    end else begin
      vrun_nxt = vrun_r;
    end
    seen_nxt = (seen_r < MAX_K) ? seen_r + CNT_W'(1) : seen_r;
    full = (seen_nxt >= k_eff);
    span = IDX_W'(1) << {k_eff, 1'b0};
    if (!full) begin
      idx = '0;
    end else if (vrun_nxt >= k_eff) begin
      idx = IDX_W'(code_nxt) & (span - IDX_W'(1));
    end else begin
      idx = span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      vrun_r <= '0;
      seen_r <= '0;
    end else if (accept) begin
      if (eos) begin
        code_r <= '0;
        vrun_r <= '0;
        seen_r <= '0;
      end else begin
        code_r <= code_nxt;
        vrun_r <= vrun_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  assign req.valid = accept;
  assign req.full  = full;
  assign req.idx   = idx;
  assign req.eos   = eos;

endmodule

>>> hdl/kpp_bitmap.sv
// Presence bitmap: epoch-tagged RAM rows, read-modify-write and distinct count.
module kpp_bitmap #(
  parameter int EPOCH_W = kpp_pkg::KPP_EPOCH_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kpp_pkg::kpp_req_t  req,
  output logic               res_valid,
  output kpp_pkg::kpp_res_t  res,
  output kpp_pkg::kpp_stat_t stat
);

  localparam int IDX_W    = kpp_pkg::KPP_IDX_W;
  localparam int ADDR_W   = kpp_pkg::KPP_ADDR_W;
  localparam int DEPTH    = kpp_pkg::KPP_RAM_DEPTH;
  localparam int SHIFT    = kpp_pkg::KPP_ROW_SHIFT;
  localparam int ROW_BITS = kpp_pkg::KPP_ROW_BITS;
  localparam int ROW_W    = EPOCH_W + ROW_BITS;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [ADDR_W-1:0]  LAST_ROW  = ADDR_W'(DEPTH - 1);

  // stage 1 (read data returns)
  logic               s1_v_r;
  logic               s1_full_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               s1_eos_r;
  logic [EPOCH_W-1:0] s1_epoch_r;

  // last write, forwarded to the next read of the same row
  logic               lw_v_r;
  logic [ADDR_W-1:0]  lw_addr_r;
  logic [ROW_W-1:0]   lw_row_r;

  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               clr_pend_r, clr_pend_nxt;
  logic               clr_act_r, clr_act_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]   distinct_r;

  logic [ADDR_W-1:0]   req_addr, s1_addr, ram_waddr;
  logic [SHIFT-1:0]    s1_bit;
  logic [ROW_W-1:0]    ram_rdata, rd_row, wr_row, ram_wdata;
  logic [ROW_BITS-1:0] row_data, new_data;
  logic                first, ram_we, ram_re;
  logic [IDX_W-1:0]    count_new;

  assign req_addr = ADDR_W'(req.idx >> SHIFT);
  assign ram_re   = req.valid && req.full;
  assign s1_addr  = ADDR_W'(s1_idx_r >> SHIFT);
  assign s1_bit   = SHIFT'(s1_idx_r);

  always_comb begin
    rd_row    = (lw_v_r && lw_addr_r == s1_addr) ? lw_row_r : ram_rdata;
    // a row tagged with an older epoch reads as cleared
    row_data  = (rd_row[ROW_W-1 -: EPOCH_W] == s1_epoch_r) ? rd_row[ROW_BITS-1:0] : '0;
    first     = s1_v_r && s1_full_r && !row_data[s1_bit];
    new_data  = row_data | (ROW_BITS'(1) << s1_bit);
    wr_row    = {s1_epoch_r, new_data};
    count_new = distinct_r + IDX_W'(first);
    ram_we    = first || clr_act_r;
    ram_waddr = clr_act_r ? clr_addr_r : s1_addr;
    ram_wdata = clr_act_r ? '0 : wr_row;
  end

  kpp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    epoch_nxt    = epoch_r;
    clr_pend_nxt = clr_pend_r;
    clr_act_nxt  = clr_act_r;
    clr_addr_nxt = clr_addr_r;
    if (req.valid && req.eos) begin
      if (epoch_r == EPOCH_MAX) begin
        epoch_nxt    = '0;
        clr_pend_nxt = 1'b1;
      end else begin
        epoch_nxt = epoch_r + EPOCH_W'(1);
      end
    end
    if (clr_pend_r && !s1_v_r) begin
      clr_pend_nxt = 1'b0;
      clr_act_nxt  = 1'b1;
      clr_addr_nxt = '0;
    end else if (clr_act_r) begin
      if (clr_addr_r == LAST_ROW) begin
        clr_act_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      lw_v_r     <= 1'b0;
      epoch_r    <= '0;
      clr_pend_r <= 1'b1;
      clr_act_r  <= 1'b0;
      clr_addr_r <= '0;
      distinct_r <= '0;
    end else begin
      s1_v_r     <= req.valid;
      lw_v_r     <= first;
      epoch_r    <= epoch_nxt;
      clr_pend_r <= clr_pend_nxt;
      clr_act_r  <= clr_act_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (s1_v_r) begin
        distinct_r <= s1_eos_r ? '0 : count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_full_r  <= req.full;
      s1_idx_r   <= req.idx;
      s1_eos_r   <= req.eos;
      s1_epoch_r <= epoch_r;
    end
    lw_addr_r <= s1_addr;
    lw_row_r  <= wr_row;
  end

  assign res_valid          = s1_v_r;
  assign res.window_full    = s1_full_r;
  assign res.kmer_index     = s1_idx_r;
  assign res.first_seen     = first;
  assign res.distinct_count = count_new;
  assign res.sequence_done  = s1_eos_r;

  assign stat.busy     = clr_pend_r || clr_act_r;
  assign stat.s1_valid = s1_v_r;

`ifndef SYNTHESIS
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> !(clr_pend_r || clr_act_r))
    else $error("request accepted during bitmap clear");

  a_clear_owns_ram: assert property (@(posedge clk) disable iff (!rst_n)
    clr_act_r |-> !s1_v_r && !first)
    else $error("bitmap update overlaps clearing pass");

  a_epoch_advances: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && req.eos |=> epoch_r != $past(epoch_r))
    else $error("epoch did not advance after end of sequence");
`endif

endmodule

>>> hdl/kpp_out_fifo.sv
// Small result queue that decouples the bitmap pipeline from the result channel.
module kpp_out_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  kpp_pkg::kpp_res_t                   push_data,
  input  logic                                pop,
  output logic                                out_valid,
  output kpp_pkg::kpp_res_t                   out_data,
  output logic [kpp_pkg::KPP_FIFO_CNT_W-1:0]  count
);

  localparam int DEPTH = kpp_pkg::KPP_FIFO_DEPTH;
  localparam int PTR_W = kpp_pkg::KPP_FIFO_PTR_W;
  localparam int CNT_W = kpp_pkg::KPP_FIFO_CNT_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  kpp_pkg::kpp_res_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

>>> hdl/kmer_presence_profiler.sv
// Top level of the k-mer presence profiler: APB register, window, bitmap, result queue.
// A result is registered in stage 1 and queued before it is offered. Throughput: one request
// per cycle when not clearing and the queue has room; the bitmap RAM does one row read and
// one write per cycle. Reset (synchronous, rst_n low) clears all control state and sets
// kmer_len to 8, then a clearing pass sweeps KPP_RAM_DEPTH rows (2049 at MAX_K = 8) of the
// bitmap RAM. It also runs after every 2**EPOCH_W sequences; no request is taken during it.
module kmer_presence_profiler #(
  parameter int EPOCH_W = kpp_pkg::KPP_EPOCH_W
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  kpp_in_if.sink                               in_ch,
  kpp_out_if.source                            out_ch,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [kpp_pkg::KPP_APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [kpp_pkg::KPP_APB_DATA_W-1:0]   cfg_pwdata,
  output logic [kpp_pkg::KPP_APB_DATA_W-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int CFG_W  = kpp_pkg::KPP_CFG_W;
  localparam int FCNT_W = kpp_pkg::KPP_FIFO_CNT_W;

  logic [CFG_W-1:0]   kmer_len_r;
  logic               reg_sel;
  logic               in_ready;
  logic               accept;
  logic               res_valid;
  logic               out_pop;
  logic [FCNT_W-1:0]  fifo_cnt;
  logic [FCNT_W:0]    in_flight;
  kpp_pkg::kpp_req_t  req;
  kpp_pkg::kpp_res_t  res;
  kpp_pkg::kpp_res_t  out_data;
  kpp_pkg::kpp_stat_t stat;

  // register file
  assign reg_sel    = (cfg_paddr[kpp_pkg::KPP_APB_ADDR_W-1:2] == kpp_pkg::KPP_REG_KMER_LEN);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? kpp_pkg::KPP_APB_DATA_W'(kmer_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= kpp_pkg::KPP_KMER_LEN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      kmer_len_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // credit check: stage 1 plus queued results never exceed the queue depth
  assign in_flight = {1'b0, fifo_cnt} + (FCNT_W + 1)'(stat.s1_valid);
  assign in_ready  = !stat.busy && (in_flight < (FCNT_W + 1)'(kpp_pkg::KPP_FIFO_DEPTH));
  assign in_ch.ready = in_ready;
  assign accept    = in_ch.valid && in_ready;

  kpp_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .base_char (in_ch.base_char),
    .eos       (in_ch.end_of_sequence),
    .kmer_len  (kmer_len_r),
    .req       (req)
  );

  kpp_bitmap #(
    .EPOCH_W (EPOCH_W)
  ) u_bitmap (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  assign out_pop = out_ch.valid && out_ch.ready;

  kpp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_pop),
    .out_valid (out_ch.valid),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

  assign out_ch.window_full    = out_data.window_full;
  assign out_ch.kmer_index     = out_data.kmer_index;
  assign out_ch.first_seen     = out_data.first_seen;
  assign out_ch.distinct_count = out_data.distinct_count;
  assign out_ch.sequence_done  = out_data.sequence_done;

endmodule

>>> verif/tb_kmer_presence_profiler.sv
// Testbench for the k-mer presence profiler: random requests checked against a bitmap predictor.
`timescale 1ns / 100ps

module tb_kmer_presence_profiler;
  import kpp_pkg::*;

  typedef struct packed {
    logic [7:0] base_char;
    logic       end_of_sequence;
  } char_req_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [KPP_APB_ADDR_W-1:0] cfg_paddr;
  logic [KPP_APB_DATA_W-1:0] cfg_pwdata;
  logic [KPP_APB_DATA_W-1:0] cfg_prdata;
  logic                      cfg_pready;

  kpp_in_if  in_ch ();
  kpp_out_if out_ch ();

  kmer_presence_profiler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_req_t char_q[$];
  kpp_res_t  profile_q[$];
  char_req_t next_req;
  kpp_res_t  want_res;
  int        err_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // Predictor state
  logic [KPP_CFG_W-1:0]  kmer_len_cfg = KPP_KMER_LEN_RST;
  logic [KPP_CODE_W-1:0] win_code = '0;
  int unsigned           run_len = 0;
  int unsigned           seen_len = 0;
  int unsigned           dist_total = 0;
  bit                    present_map[int unsigned];

  task automatic report_mismatch(input string field, input int got, input int want);
    if (err_count < 30)
      $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    err_count++;
  endtask

  // One request in, one profile result out; clears per-sequence state on end of sequence.
  function automatic kpp_res_t profile_step(input logic [7:0] ch, input logic eos);
    logic [7:0]  up;
    logic [1:0]  sym;
    logic        sym_ok;
    int unsigned k;
    int unsigned span;
    int unsigned idx;
    kpp_res_t    r;
    k = (kmer_len_cfg == 0) ? 1 : (kmer_len_cfg > KPP_MAX_K) ? KPP_MAX_K : kmer_len_cfg;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    sym_ok = 1'b1;
    sym = KPP_SYM_A;
    case (up)
      "A": sym = KPP_SYM_A;
      "C": sym = KPP_SYM_C;
      "G": sym = KPP_SYM_G;
      "T", "U": sym = KPP_SYM_T;
      default: sym_ok = 1'b0;
    endcase
    // invalid characters shift in a zero digit and break the valid run
    win_code = {win_code[KPP_CODE_W-3:0], sym_ok ? sym : KPP_SYM_A};
    if (!sym_ok) run_len = 0;
    else if (run_len < KPP_MAX_K) run_len++;
    if (seen_len < KPP_MAX_K) seen_len++;
    r = '0;
    r.window_full = (seen_len >= k);
    if (r.window_full) begin
      span = 1 << (2 * k);
      idx = (run_len >= k) ? (win_code & (span - 1)) : span;
      if (!present_map.exists(idx)) begin
        present_map[idx] = 1'b1;
        r.first_seen = 1'b1;
        dist_total++;
      end
      r.kmer_index = KPP_IDX_W'(idx);
    end
    r.distinct_count = KPP_IDX_W'(dist_total);
    r.sequence_done = eos;
    if (eos) begin
      win_code = '0;
      run_len = 0;
      seen_len = 0;
      dist_total = 0;
      present_map.delete();
    end
    return r;
  endfunction

  // Mostly bases in either case, some arbitrary bytes.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(99) < 12) return 8'($urandom);
    case ($urandom_range(4))
      0: c = "A";
      1: c = "C";
      2: c = "G";
      3: c = "T";
      default: c = "U";
    endcase
    if ($urandom_range(1) != 0) c = c | 8'h20;
    return c;
  endfunction

  // Request driver; the expected result is computed as each request is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        profile_q.insert(profile_q.size(),
                         profile_step(in_ch.base_char, in_ch.end_of_sequence));
      if (!in_ch.valid || in_ch.ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = char_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.base_char <= next_req.base_char;
          in_ch.end_of_sequence <= next_req.end_of_sequence;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (profile_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want_res = profile_q.pop_front();
          if (out_ch.window_full !== want_res.window_full)
            report_mismatch("window_full", out_ch.window_full, want_res.window_full);
          if (out_ch.kmer_index !== want_res.kmer_index)
            report_mismatch("kmer_index", out_ch.kmer_index, want_res.kmer_index);
          if (out_ch.first_seen !== want_res.first_seen)
            report_mismatch("first_seen", out_ch.first_seen, want_res.first_seen);
          if (out_ch.distinct_count !== want_res.distinct_count)
            report_mismatch("distinct_count", out_ch.distinct_count, want_res.distinct_count);
          if (out_ch.sequence_done !== want_res.sequence_done)
            report_mismatch("sequence_done", out_ch.sequence_done, want_res.sequence_done);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Write kmer_len, then read it back.
  task automatic write_kmer_len(input logic [KPP_CFG_W-1:0] len);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {KPP_REG_KMER_LEN, 2'b00};
    cfg_pwdata <= ($urandom << KPP_CFG_W) | len;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    kmer_len_cfg = len;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[KPP_CFG_W-1:0] !== len)
      report_mismatch("kmer_len readback", cfg_prdata[KPP_CFG_W-1:0], len);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (char_q.size() != 0 || in_ch.valid || profile_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_chars(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++)
      char_q.insert(char_q.size(), char_req_t'{s[i], eos_last && (i == s.len() - 1)});
  endtask

  initial begin
    logic [KPP_CFG_W-1:0] len_plan[8];
    logic [7:0]           motif[4];
    logic [7:0]           ch;
    int                   seq_left;
    int                   motif_len;
    int                   pos;
    int                   rand_items;
    int                   seq_total;
    len_plan = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd2, 4'd9, 4'd5, 4'd8};
    seq_left = 0;
    motif_len = 0;
    pos = 0;
    rand_items = 0;
    seq_total = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.base_char = '0;
    in_ch.end_of_sequence = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 57;
    // reset length 8: window fills on the eighth base, then invalid bytes give the sentinel
    add_chars("AcGtUaCgT", 1'b0);
    char_q.insert(char_q.size(), char_req_t'{8'h00, 1'b0});
    char_q.insert(char_q.size(), char_req_t'{"N", 1'b0});
    char_q.insert(char_q.size(), char_req_t'{8'hFF, 1'b1});
    wait_drained();
    write_kmer_len(4'd1);
    // bytes just outside the lower-case range stay invalid; T and U share an index
    add_chars("aAz`{ut", 1'b1);
    wait_drained();

    for (int sub = 0; sub < 12; sub++) begin
      send_idle_pct = (sub < 4) ? 27 : (sub < 8) ? 57 : 0;
      recv_idle_pct = (sub < 4) ? 57 : (sub < 8) ? 27 : 0;
      // a sequence left open here sees the length change mid-stream
      write_kmer_len((sub < 8) ? len_plan[sub] : KPP_CFG_W'($urandom_range(15)));
      while (rand_items < (sub + 1) * 92 || (sub == 11 && seq_total < 290)) begin
        if (seq_left == 0) begin
          seq_left = ($urandom_range(99) < 75) ? 1 : $urandom_range(2, 24);
          motif_len = ($urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
          for (int m = 0; m < 4; m++) motif[m] = pick_char();
          pos = 0;
        end
        ch = (motif_len != 0 && $urandom_range(9) != 0) ? motif[pos % motif_len] : pick_char();
        seq_left--;
        pos++;
        char_q.insert(char_q.size(), char_req_t'{ch, seq_left == 0});
        if (seq_left == 0) seq_total++;
        rand_items++;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
